FILE: design/greedy_paragraph_wrapper_assert.svh
// assertion macros shared by the wrapper checks
`ifndef GREEDY_PARAGRAPH_WRAPPER_ASSERT_SVH
`define GREEDY_PARAGRAPH_WRAPPER_ASSERT_SVH

// overlapping implication, checked on every rising edge unless dis is high
`define GPW_ASSERT_NOW(label, clk, dis, ante, cons) \
    label: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
        else $error("gpw check failed");

// next-cycle implication, checked on every rising edge unless dis is high
`define GPW_ASSERT_NEXT(label, clk, dis, ante, cons) \
    label: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
        else $error("gpw check failed");

`endif

FILE: design/gpw_pkg.sv
// types, constants and control store of the greedy paragraph wrapper
`timescale 1ns / 1ps

package gpw_pkg;

    localparam int COL_W = 12;
    localparam int SUM_W = COL_W + 2;
    localparam int CH_W  = 8;

    localparam logic [COL_W-1:0] LINE_WIDTH_RESET = 12'd72;
    localparam logic [CH_W-1:0]  CH_SPACE         = 8'd32;
    localparam logic [CH_W-1:0]  CH_NEWLINE       = 8'd10;

    typedef enum logic [1:0] {
        KIND_CHAR,
        KIND_SPACE,
        KIND_NEWLINE,
        KIND_END
    } t_kind;

    typedef enum logic [3:0] {
        STEP_IDLE,
        STEP_CHR,
        STEP_FL_CHK,
        STEP_FL_PRE,
        STEP_FL_BYTE,
        STEP_T_SP,
        STEP_T_NL,
        STEP_T_NL2,
        STEP_T_END
    } t_step;

    typedef enum logic [3:0] {
        OP_WAIT,
        OP_STORE,
        OP_NOP,
        OP_PREFIX,
        OP_BYTE,
        OP_SPACE_TAIL,
        OP_NL_CLOSE,
        OP_NL_EMPTY,
        OP_END_TAIL
    } t_op;

    typedef enum logic [1:0] {
        COND_NONE,
        COND_LEN_ZERO,
        COND_LAST_BYTE
    } t_cond;

    typedef enum logic [1:0] {
        NXT_SEQ,
        NXT_HOLD,
        NXT_IDLE
    } t_next;

    // one control word: datapath operation, branch condition (taken -> tail), fall-through
    typedef struct packed {
        t_op   op;
        t_cond cond;
        t_next nxt;
    } t_uword;

    function automatic t_uword ucode(input t_step s);
        t_uword w;
        case (s)
            STEP_CHR:     w = '{op: OP_STORE,      cond: COND_NONE,      nxt: NXT_IDLE};
            STEP_FL_CHK:  w = '{op: OP_NOP,        cond: COND_LEN_ZERO,  nxt: NXT_SEQ};
            STEP_FL_PRE:  w = '{op: OP_PREFIX,     cond: COND_NONE,      nxt: NXT_SEQ};
            STEP_FL_BYTE: w = '{op: OP_BYTE,       cond: COND_LAST_BYTE, nxt: NXT_HOLD};
            STEP_T_SP:    w = '{op: OP_SPACE_TAIL, cond: COND_NONE,      nxt: NXT_IDLE};
            STEP_T_NL:    w = '{op: OP_NL_CLOSE,   cond: COND_NONE,      nxt: NXT_SEQ};
            STEP_T_NL2:   w = '{op: OP_NL_EMPTY,   cond: COND_NONE,      nxt: NXT_IDLE};
            STEP_T_END:   w = '{op: OP_END_TAIL,   cond: COND_NONE,      nxt: NXT_IDLE};
            default:      w = '{op: OP_WAIT,       cond: COND_NONE,      nxt: NXT_HOLD};
        endcase
        return w;
    endfunction

endpackage

FILE: design/greedy_paragraph_wrapper.sv
// greedy paragraph wrapper: microcoded sequencer over a word buffer and column tracker
`timescale 1ns / 1ps
// a plain text byte is accepted in the transfer, then runs one store step
// space and end items run the flush check and one tail step, newline two; a pending word adds
// a prefix step and the byte loop, one word byte per cycle from the word buffer read port
// while the output is not stalled
// reset (i_rst_n low, synchronous) clears all control state but the item kind, sets line width to 72

module greedy_paragraph_wrapper #(
    parameter int MAX_WORD = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // configuration: line width, written whenever i_cfg_we is high
    input  logic       i_cfg_we,
    input  logic [11:0] i_cfg_wdata,
    // input stream
    input  logic       i_s_tvalid,
    output logic       o_s_tready,
    input  logic [7:0] i_s_tdata,   // [7:0] ch
    input  logic       i_s_tuser,   // [0] is_end
    // output stream
    output logic       o_m_tvalid,
    input  logic       i_m_tready,
    output logic [7:0] o_m_tdata,   // [7:0] out_char
    output logic       o_m_tlast,   // run_last
    output logic       o_m_tuser    // [0] truncated
);

    localparam int IDX_W = (MAX_WORD > 1) ? $clog2(MAX_WORD) : 1;
    localparam int LEN_W = $clog2(MAX_WORD + 1);
    localparam int COL_W = gpw_pkg::COL_W;
    localparam int SUM_W = gpw_pkg::SUM_W;

    // control registers
    gpw_pkg::t_step    r_pc, n_pc;
    gpw_pkg::t_kind    r_kind;
    logic [LEN_W-1:0]  r_len, n_len;
    logic [IDX_W-1:0]  r_idx, n_idx;
    logic              r_ovf, n_ovf;
    logic [COL_W-1:0]  r_col, n_col;
    logic              r_para, n_para;
    logic              r_lhc, n_lhc;
    logic [COL_W-1:0]  r_line_width;
    logic              r_out_valid;

    // payload registers
    logic [7:0]        r_ch;
    logic [7:0]        r_rd_data;
    logic [7:0]        r_out_char;
    logic              r_out_last;
    logic              r_out_trunc;

    // word buffer
    logic [7:0]        r_mem [MAX_WORD];

    gpw_pkg::t_uword   uw;
    gpw_pkg::t_kind    in_kind;
    gpw_pkg::t_step    tail_step;
    logic              in_xfer;
    logic              slot_free;
    logic              wants_emit;
    logic              emit_fire;
    logic              step_go;
    logic              cond_hit;
    logic              last_byte;
    logic              has_tail;
    logic              over;
    logic              mem_we;
    logic [SUM_W-1:0]  col_sum;
    logic [7:0]        emit_char;
    logic              emit_last;
    logic              emit_trunc;

    assign o_s_tready = (r_pc == gpw_pkg::STEP_IDLE) && i_rst_n;
    assign in_xfer    = i_s_tvalid && o_s_tready;
    assign slot_free  = !r_out_valid || i_m_tready;

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_char;
    assign o_m_tlast  = r_out_last;
    assign o_m_tuser  = r_out_trunc;

    // classify the incoming byte
    always_comb begin
        if (i_s_tuser) begin
            in_kind = gpw_pkg::KIND_END;
        end else if (i_s_tdata == gpw_pkg::CH_SPACE) begin
            in_kind = gpw_pkg::KIND_SPACE;
        end else if (i_s_tdata == gpw_pkg::CH_NEWLINE) begin
            in_kind = gpw_pkg::KIND_NEWLINE;
        end else begin
            in_kind = gpw_pkg::KIND_CHAR;
        end
    end

    // where the flush routine returns to, per item kind
    always_comb begin
        case (r_kind)
            gpw_pkg::KIND_SPACE:   tail_step = gpw_pkg::STEP_T_SP;
            gpw_pkg::KIND_NEWLINE: tail_step = gpw_pkg::STEP_T_NL;
            gpw_pkg::KIND_END:     tail_step = gpw_pkg::STEP_T_END;
            default:               tail_step = gpw_pkg::STEP_IDLE;
        endcase
    end

    assign uw        = gpw_pkg::ucode(r_pc);
    assign last_byte = ((LEN_W'(r_idx) + LEN_W'(1)) == r_len);
    // after the word, an end item always closes its paragraph; a newline adds
    // output only when it ends an empty input line
    assign has_tail  = (r_kind == gpw_pkg::KIND_END) ||
                       ((r_kind == gpw_pkg::KIND_NEWLINE) && !r_lhc);
    assign col_sum   = {2'b00, r_col} + SUM_W'(1) + SUM_W'(r_len);
    assign over      = col_sum > {2'b00, r_line_width};

    // what the current step puts on the output
    always_comb begin
        wants_emit = 1'b0;
        emit_char  = gpw_pkg::CH_NEWLINE;
        emit_last  = 1'b0;
        emit_trunc = 1'b0;
        case (uw.op)
            gpw_pkg::OP_PREFIX: begin
                wants_emit = r_para;
                emit_char  = over ? gpw_pkg::CH_NEWLINE : gpw_pkg::CH_SPACE;
                emit_trunc = r_ovf;
            end
            gpw_pkg::OP_BYTE: begin
                wants_emit = 1'b1;
                emit_char  = r_rd_data;
                emit_last  = last_byte && !has_tail;
                emit_trunc = r_ovf;
            end
            gpw_pkg::OP_NL_CLOSE: begin
                wants_emit = !r_lhc && r_para;
            end
            gpw_pkg::OP_NL_EMPTY: begin
                wants_emit = !r_lhc;
                emit_last  = 1'b1;
            end
            gpw_pkg::OP_END_TAIL: begin
                wants_emit = r_para;
                emit_last  = 1'b1;
            end
            default: begin
                wants_emit = 1'b0;
            end
        endcase
    end

    // a step that must emit waits for a free output slot
    assign step_go   = !(wants_emit && !slot_free);
    assign emit_fire = wants_emit && slot_free;

    always_comb begin
        case (uw.cond)
            gpw_pkg::COND_LEN_ZERO:  cond_hit = (r_len == '0);
            gpw_pkg::COND_LAST_BYTE: cond_hit = last_byte;
            default:                 cond_hit = 1'b0;
        endcase
    end

    // sequencer and datapath next state
    always_comb begin
        n_pc   = r_pc;
        n_len  = r_len;
        n_idx  = r_idx;
        n_ovf  = r_ovf;
        n_col  = r_col;
        n_para = r_para;
        n_lhc  = r_lhc;
        mem_we = 1'b0;

        if (r_pc == gpw_pkg::STEP_IDLE) begin
            if (in_xfer) begin
                n_pc = (in_kind == gpw_pkg::KIND_CHAR) ? gpw_pkg::STEP_CHR
                                                       : gpw_pkg::STEP_FL_CHK;
            end
        end else if (step_go) begin
            if (cond_hit) begin
                n_pc = tail_step;
            end else begin
                case (uw.nxt)
                    gpw_pkg::NXT_SEQ:  n_pc = gpw_pkg::t_step'(r_pc + 4'd1);
                    gpw_pkg::NXT_IDLE: n_pc = gpw_pkg::STEP_IDLE;
                    default:           n_pc = r_pc;
                endcase
            end

            case (uw.op)
                gpw_pkg::OP_STORE: begin
                    n_lhc = 1'b1;
                    if (r_len < LEN_W'(MAX_WORD)) begin
                        mem_we = 1'b1;
                        n_len  = r_len + LEN_W'(1);
                    end else begin
                        n_ovf = 1'b1;
                    end
                end
                gpw_pkg::OP_PREFIX: begin
                    if (r_para && !over) begin
                        n_col = col_sum[COL_W-1:0];
                    end else begin
                        n_col = COL_W'(r_len);
                    end
                    n_para = 1'b1;
                end
                gpw_pkg::OP_BYTE: begin
                    if (last_byte) begin
                        n_len = '0;
                        n_ovf = 1'b0;
                        n_idx = '0;
                    end else begin
                        n_idx = r_idx + IDX_W'(1);
                    end
                end
                gpw_pkg::OP_SPACE_TAIL: begin
                    n_lhc = 1'b1;
                end
                gpw_pkg::OP_NL_CLOSE: begin
                    if (!r_lhc && r_para) begin
                        n_para = 1'b0;
                        n_col  = '0;
                    end
                end
                gpw_pkg::OP_NL_EMPTY: begin
                    n_lhc = 1'b0;
                end
                gpw_pkg::OP_END_TAIL: begin
                    n_len  = '0;
                    n_idx  = '0;
                    n_ovf  = 1'b0;
                    n_col  = '0;
                    n_para = 1'b0;
                    n_lhc  = 1'b0;
                end
                default: begin
                    n_pc = n_pc;
                end
            endcase
        end
    end

    // control state and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc         <= gpw_pkg::STEP_IDLE;
            r_len        <= '0;
            r_idx        <= '0;
            r_ovf        <= 1'b0;
            r_col        <= '0;
            r_para       <= 1'b0;
            r_lhc        <= 1'b0;
            r_line_width <= gpw_pkg::LINE_WIDTH_RESET;
            r_out_valid  <= 1'b0;
        end else begin
            r_pc   <= n_pc;
            r_len  <= n_len;
            r_idx  <= n_idx;
            r_ovf  <= n_ovf;
            r_col  <= n_col;
            r_para <= n_para;
            r_lhc  <= n_lhc;
            if (i_cfg_we) begin
                r_line_width <= i_cfg_wdata;
            end
            if (emit_fire) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload: latched item and output byte
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_ch   <= i_s_tdata;
            r_kind <= in_kind;
        end
        if (emit_fire) begin
            r_out_char  <= emit_char;
            r_out_last  <= emit_last;
            r_out_trunc <= emit_trunc;
        end
    end

    // word buffer: one write port at the fill count, registered read at the next index
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_len[IDX_W-1:0]] <= r_ch;
        end
        r_rd_data <= r_mem[n_idx];
    end

endmodule

FILE: design/gpw_checker.sv
// port-level checks of the greedy paragraph wrapper, bound to the top level
`timescale 1ns / 1ps
`include "greedy_paragraph_wrapper_assert.svh"

module gpw_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_cfg_we,
    input logic [11:0] i_cfg_wdata,
    input logic        i_s_tvalid,
    input logic        o_s_tready,
    input logic [7:0]  i_s_tdata,
    input logic        i_s_tuser,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [7:0]  o_m_tdata,
    input logic        o_m_tlast,
    input logic        o_m_tuser
);

    // a stalled output transfer holds its payload
    `GPW_ASSERT_NEXT(a_out_hold, i_clk, !i_rst_n, o_m_tvalid && !i_m_tready, o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tlast) && $stable(o_m_tuser))

    // the last byte of a run is a word byte or a newline, never a space prefix
    `GPW_ASSERT_NOW(a_last_not_space, i_clk, !i_rst_n, o_m_tvalid && o_m_tlast, o_m_tdata != gpw_pkg::CH_SPACE)

    // reset leaves no result pending
    `GPW_ASSERT_NEXT(a_reset_empty, i_clk, 1'b0, !i_rst_n, !o_m_tvalid)

    // an accepted item always runs at least one program step before the next is taken
    `GPW_ASSERT_NEXT(a_busy_after_xfer, i_clk, !i_rst_n, i_s_tvalid && o_s_tready, !o_s_tready)

endmodule

bind greedy_paragraph_wrapper gpw_checker u_gpw_checker (.*);
